[design/rdp_pkg.sv]
// ----------------------------------------------------------------------------
// rdp_pkg - shared types and constants for the rotary dial pulse decoder
// Command format between front and back, state codes, counter limits.
// ----------------------------------------------------------------------------
package rdp_pkg;

  // default number of digits the store holds
  localparam int MAX_DIGITS_DEF = 20;

  // depth of the command queue between front and back (power of two)
  localparam int CMD_DEPTH = 4;

  // configuration register indexes
  localparam logic CFG_GUARD   = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam int CFG_DATA_W = 16;

  // reset values of the configuration registers
  localparam logic [9:0]  GUARD_RESET   = 10'd70;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

  // saturation limits
  localparam logic [4:0]  COUNT_MAX = 5'd31;
  localparam logic [9:0]  SINCE_MAX = 10'd1023;
  localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

  // ten pulses dial a zero
  localparam logic [4:0]  ZERO_PULSES = 5'd10;
  localparam logic [4:0]  NINE_PULSES = 5'd9;

  // one queue entry: optional digit write, then optional send of the number
  typedef struct packed {
    logic       wr;
    logic [3:0] digit;
    logic       send;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SEND
  } back_state_t;

endpackage

[design/rdp_front.sv]
// ----------------------------------------------------------------------------
// rdp_front - tick classifier
// Edge detection, pulse counting with guard, idle timer and send decision.
// Emits digit-write and send commands into the command queue.
// ----------------------------------------------------------------------------
module rdp_front #(
  parameter int MAX_DIGITS = rdp_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            dial_line,
  input  logic                            pulse_line,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [rdp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            cmd_full,
  output logic                            cmd_push,
  output rdp_pkg::cmd_t                   cmd
);
  import rdp_pkg::*;

  localparam int HW = $clog2(MAX_DIGITS + 1);

  logic [9:0]    guard;
  logic [15:0]   timeout;
  logic          prev_dial;
  logic          prev_pulse;
  logic [4:0]    pulse_count;
  logic [9:0]    since_pulse;
  logic [15:0]   idle_ms;
  logic [HW-1:0] held;
  logic          pending;

  logic [4:0]    pulse_count_next;
  logic [9:0]    since_pulse_next;
  logic [15:0]   idle_ms_next;
  logic [HW-1:0] held_next;
  logic          pending_next;
  logic          accept;

  assign accept = push && !cmd_full;

  always_comb begin
    pulse_count_next = pulse_count;
    since_pulse_next = (since_pulse < SINCE_MAX) ? since_pulse + 10'd1 : since_pulse;
    idle_ms_next     = (idle_ms < IDLE_MAX) ? idle_ms + 16'd1 : idle_ms;
    held_next        = held;
    pending_next     = pending;
    cmd              = '0;

    // dial starts turning
    if (prev_dial && !dial_line) begin
      pulse_count_next = '0;
    end

    // pulse edge while dialing, past the guard time
    if (prev_pulse && !pulse_line && !dial_line && (since_pulse_next > guard)) begin
      since_pulse_next = '0;
      if (pulse_count_next < COUNT_MAX) begin
        pulse_count_next = pulse_count_next + 5'd1;
      end
    end

    // dial released; a full store drops the digit entirely
    if (!prev_dial && dial_line && (held < HW'(MAX_DIGITS))) begin
      if (pulse_count_next == ZERO_PULSES) begin
        cmd.wr    = 1'b1;
        cmd.digit = 4'd0;
      end else if (pulse_count_next != 5'd0 && pulse_count_next <= NINE_PULSES) begin
        cmd.wr    = 1'b1;
        cmd.digit = pulse_count_next[3:0];
      end
      idle_ms_next     = '0;
      pending_next     = 1'b1;
      pulse_count_next = '0;
    end

    held_next = held + HW'(cmd.wr);

    if (pending_next && (idle_ms_next > timeout) && (held_next != '0)) begin
      cmd.send     = 1'b1;
      held_next    = '0;
      pending_next = 1'b0;
    end
  end

  assign cmd_push = accept && (cmd.wr || cmd.send);

  always_ff @(posedge clk) begin
    if (rst) begin
      guard   <= GUARD_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GUARD:   guard   <= cfg_data[9:0];
        CFG_TIMEOUT: timeout <= cfg_data[15:0];
        default:     guard   <= guard;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_dial   <= 1'b1;
      prev_pulse  <= 1'b1;
      pulse_count <= '0;
      since_pulse <= '0;
      idle_ms     <= '0;
      held        <= '0;
      pending     <= 1'b0;
    end else if (accept) begin
      prev_dial   <= dial_line;
      prev_pulse  <= pulse_line;
      pulse_count <= pulse_count_next;
      since_pulse <= since_pulse_next;
      idle_ms     <= idle_ms_next;
      held        <= held_next;
      pending     <= pending_next;
    end
  end

endmodule

[design/rdp_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// rdp_cmd_fifo - command queue between front and back
// Small flop-based FIFO of cmd_t entries.
// ----------------------------------------------------------------------------
module rdp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  rdp_pkg::cmd_t wr_data,
  input  logic          rd_en,
  output rdp_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);
  import rdp_pkg::*;

  localparam int PW = $clog2(CMD_DEPTH);

  cmd_t          slots [CMD_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;

  assign full    = (cnt == (PW+1)'(CMD_DEPTH));
  assign empty   = (cnt == '0);
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) begin
        wp <= wp + PW'(1);
      end
      if (rd_en) begin
        rp <= rp + PW'(1);
      end
      cnt <= cnt + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end

endmodule

[design/rdp_back.sv]
// ----------------------------------------------------------------------------
// rdp_back - digit store and number sender
// Executes queued commands: writes digits, then streams the number out.
// ----------------------------------------------------------------------------
module rdp_back #(
  parameter int MAX_DIGITS = rdp_pkg::MAX_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  rdp_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          pop,
  output logic          empty,
  output logic [3:0]    digit_value,
  output logic          last_digit
);
  import rdp_pkg::*;

  localparam int HW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  back_state_t   state;
  back_state_t   state_next;
  logic [HW-1:0] held;
  logic [IW-1:0] idx;
  logic [3:0]    mem [MAX_DIGITS];
  logic [3:0]    mem_q;
  logic          o_valid;

  logic          slot_free;
  logic          emit;
  logic          is_last;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] rd_addr;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!cmd_empty && cmd.send) begin
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: state_next = BK_SEND;
      BK_SEND: begin
        if (slot_free && is_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs / datapath control
  always_comb begin
    slot_free = !o_valid || pop;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    case (state)
      BK_IDLE:  cmd_pop = !cmd_empty;
      BK_FETCH: emit    = 1'b0;
      BK_SEND:  emit    = slot_free;
      default:  cmd_pop = 1'b0;
    endcase
    is_last = (HW'(idx) == held - HW'(1));
    idx_inc = (idx == IW'(MAX_DIGITS - 1)) ? '0 : idx + IW'(1);
    rd_addr = emit ? idx_inc : idx;
  end

  // digit store, registered read
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.wr) begin
      mem[held[IW-1:0]] <= cmd.digit;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      held    <= '0;
      idx     <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop && cmd.wr) begin
        held <= held + HW'(1);
      end else if (emit && is_last) begin
        held <= '0;
      end
      if (cmd_pop) begin
        idx <= '0;
      end else if (emit) begin
        idx <= idx_inc;
      end
      if (emit) begin
        o_valid <= 1'b1;
      end else if (pop) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      digit_value <= mem_q;
      last_digit  <= is_last;
    end
  end

  assign empty = !o_valid;

  // a number is never sent from an empty store
  a_send_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> (held != '0))
    else $error("rdp_back: sending with no digits held");

  // read index stays inside the held digits while sending
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SEND) |-> (HW'(idx) < held))
    else $error("rdp_back: read index past held digits");

  // the prime cycle always leads into streaming
  a_fetch_send: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FETCH) |=> (state == BK_SEND))
    else $error("rdp_back: fetch not followed by send");

  // no command is taken while a number is streaming
  a_no_pop_send: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> !cmd_pop)
    else $error("rdp_back: command taken mid-send");

endmodule

[design/rotary_dial_pulse_decoder.sv]
// ----------------------------------------------------------------------------
// rotary_dial_pulse_decoder - rotary dial pulse decoder, top level
// Decodes millisecond-sampled dial and pulse lines into dialed numbers.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying the sampled dial_line
// (0 while the dial turns) and pulse_line. Pulses are counted on falling
// pulse edges while dialing, only when more than pulse_guard_ms ticks passed
// since the last counted pulse; on dial release 1..9 pulses store that digit
// and 10 store a zero. Once dial_timeout_ms idle ticks have passed since the
// last release and digits are held, the whole number comes out as a run of
// result beats, one digit each in dial order, last_digit marking the final
// one. The front takes a tick while full is low; ticks that produce a store
// or send command go into a 4-entry command queue, and full is raised only
// when that queue is full. After a fetch state that primes the registered
// store read, the back streams a held number at one digit per cycle while
// pop keeps the output slot free; the front keeps taking ticks meanwhile
// while the queue has room. Configuration writes (index 0: pulse guard,
// index 1: timeout) take effect at once and should be made while the block
// is idle.
// ----------------------------------------------------------------------------
module rotary_dial_pulse_decoder #(
  parameter int MAX_DIGITS = rdp_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // tick input
  input  logic                           push,
  output logic                           full,
  input  logic                           dial_line,
  input  logic                           pulse_line,
  // digit output
  output logic                           empty,
  input  logic                           pop,
  output logic [3:0]                     digit_value,
  output logic                           last_digit,
  // configuration
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [rdp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rdp_pkg::*;

  cmd_t q_wr_data;
  cmd_t q_rd_data;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // full reflects only queue space: every tick fits one queue entry
  assign full = q_full;

  rdp_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .dial_line  (dial_line),
    .pulse_line (pulse_line),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_full   (q_full),
    .cmd_push   (q_push),
    .cmd        (q_wr_data)
  );

  rdp_cmd_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  rdp_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (q_empty),
    .cmd         (q_rd_data),
    .cmd_pop     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .digit_value (digit_value),
    .last_digit  (last_digit)
  );

endmodule

[tb/sv/rotary_dial_pulse_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_dial_pulse_decoder_tb - self-checking bench for the dial decoder
// Drives millisecond tick beats through the push/full side, decodes the same
// ticks in a local model of the dial, and checks every digit beat popped from
// the result side against the digits that model predicts.
// ----------------------------------------------------------------------------
module rotary_dial_pulse_decoder_tb;
  import rdp_pkg::*;

  localparam int DIGIT_SLOTS = MAX_DIGITS_DEF;
  // settle time after the last expected digit; leave plenty of room
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [3:0] value;
    logic       last;
  } dialed_digit_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        dial_line;
  logic        pulse_line;
  logic        empty;
  logic        pop;
  logic [3:0]  digit_value;
  logic        last_digit;
  logic        cfg_we;
  logic        cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rotary_dial_pulse_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .dial_line   (dial_line),
    .pulse_line  (pulse_line),
    .empty       (empty),
    .pop         (pop),
    .digit_value (digit_value),
    .last_digit  (last_digit),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Local copy of the dial state and the two registers
  // --------------------------------------------------------------------------
  logic [9:0]  guard_ticks;
  logic [15:0] timeout_ticks;
  logic        dial_was;
  logic        pulse_was;
  logic [4:0]  pulse_tally;
  logic [9:0]  since_pulse;
  logic [15:0] idle_ticks;
  logic [3:0]  number_digits [DIGIT_SLOTS];
  int          digits_stored;
  logic        number_ready;

  // digits predicted but not yet popped, oldest first
  dialed_digit_t pending_digits[$];

  int  tick_count;        // tick beats accepted
  int  mismatch_count;
  int  cycle_count;
  // per-beat stall limits for each side, changed between phases
  int  tick_gap_max;
  int  pop_gap_max;
  int  pop_wait;          // cycles pop stays low before the next digit beat

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap(int max_gap);
    if (max_gap == 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  // --------------------------------------------------------------------------
  // Dial decoding for one tick: counters step first, then the falling dial
  // edge, the pulse edge, the release, and last the send check.
  // --------------------------------------------------------------------------
  function automatic void decode_tick(logic dial, logic pulse);
    dialed_digit_t d;
    if (since_pulse != SINCE_MAX) since_pulse++;
    if (idle_ticks != IDLE_MAX) idle_ticks++;
    if (dial_was && !dial) pulse_tally = '0;
    // pulse only counts while the dial turns and outside the guard window
    if (pulse_was && !pulse && !dial && since_pulse > guard_ticks) begin
      since_pulse = '0;
      if (pulse_tally != COUNT_MAX) pulse_tally++;
    end
    // release; with a full store the whole release is dropped
    if (!dial_was && dial && digits_stored < DIGIT_SLOTS) begin
      if (pulse_tally == ZERO_PULSES) begin
        number_digits[digits_stored] = 4'd0;
        digits_stored++;
      end else if (pulse_tally != '0 && pulse_tally <= NINE_PULSES) begin
        number_digits[digits_stored] = pulse_tally[3:0];
        digits_stored++;
      end
      // bad counts still restart the idle timer and arm the send
      idle_ticks = '0;
      number_ready = 1'b1;
      pulse_tally = '0;
    end
    dial_was = dial;
    pulse_was = pulse;
    if (number_ready && idle_ticks > timeout_ticks && digits_stored > 0) begin
      for (int i = 0; i < digits_stored; i++) begin
        d.value = number_digits[i];
        d.last = (i == digits_stored - 1);
        pending_digits.push_back(d);
      end
      digits_stored = 0;
      number_ready = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: pop stalls at random, each popped beat is checked
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string what, dialed_digit_t want, logic [3:0] got_value,
                               logic got_last);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("tb: %s: expected digit %0d last %0b, got digit %0d last %0b",
               what, want.value, want.last, got_value, got_last);
  endtask

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_wait > 0) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_digits.size() == 0) begin
        note_mismatch("digit beat with none expected", '{4'd0, 1'b0}, digit_value,
                      last_digit);
      end else if (digit_value !== pending_digits[0].value ||
                   last_digit !== pending_digits[0].last) begin
        note_mismatch("digit beat mismatch", pending_digits[0], digit_value, last_digit);
        void'(pending_digits.pop_front());
      end else begin
        void'(pending_digits.pop_front());
      end
      pop_wait = pick_gap(pop_gap_max);
    end
  end

  // --------------------------------------------------------------------------
  // Tick side
  // --------------------------------------------------------------------------
  // one tick beat; push stays high afterwards so back-to-back beats keep it up
  task automatic send_tick(logic dial, logic pulse);
    int gap;
    gap = pick_gap(tick_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    dial_line <= dial;
    pulse_line <= pulse;
    do @(posedge clk); while (full);
    decode_tick(dial, pulse);
    tick_count++;
  endtask

  // stop sending, wait for every predicted digit, then let the block settle
  task automatic wait_for_results();
    @(negedge clk);
    push <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with push low and nothing outstanding
  task automatic set_register(logic idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GUARD) guard_ticks = value[9:0];
    else timeout_ticks = value;
  endtask

  // one turn of the dial: falling dial edge, pulses just past a guard up to 7,
  // else eight ticks apart (some too close on purpose), release with pulse high
  task automatic dial_digit(int pulses, int short_pct);
    int spacing;
    send_tick(1'b0, 1'b1);
    repeat (pulses) begin
      spacing = (guard_ticks < 7) ? int'(guard_ticks) + 1 : 8;
      if ($urandom_range(0, 99) < short_pct && spacing > 2)
        spacing = $urandom_range(2, spacing - 1);
      send_tick(1'b0, 1'b0);
      repeat (spacing - 1) send_tick(1'b0, 1'b1);
    end
    send_tick(1'b1, 1'b1);
  endtask

  task automatic idle_ticks_for(int count);
    repeat (count) send_tick(1'b1, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset registers, every combination of both lines, pulse edges with the
  // dial at rest; the guard is still closed so nothing counts
  task automatic test_line_extremes();
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    wait_for_results();
  endtask

  // zero and over-ten pulses arm a send with nothing held; the number goes
  // out only once a real digit is stored
  task automatic test_bad_counts();
    set_register(CFG_GUARD, 16'd1);
    set_register(CFG_TIMEOUT, 16'd4);
    dial_digit(0, 0);
    idle_ticks_for(6);
    dial_digit(11, 0);
    idle_ticks_for(6);
    dial_digit(10, 0);
    dial_digit(9, 0);
    idle_ticks_for(6);
    wait_for_results();
  endtask

  // a guard at the counter limit never counts; then a guard of 1000, and a
  // small guard with pulses landing inside the window
  task automatic test_guard_limits();
    set_register(CFG_GUARD, 16'd1023);
    dial_digit(3, 0);
    wait_for_results();
    set_register(CFG_GUARD, 16'd1000);
    dial_digit(2, 0);
    idle_ticks_for(6);
    wait_for_results();
    set_register(CFG_GUARD, 16'd3);
    dial_digit(4, 50);
    dial_digit(3, 50);
    idle_ticks_for(6);
    wait_for_results();
  endtask

  // the largest timeout holds the number; more than a full store of digits
  // is dialed, then a short timeout sends all that fit
  task automatic test_full_store();
    set_register(CFG_GUARD, 16'd1);
    set_register(CFG_TIMEOUT, 16'hFFFF);
    repeat (DIGIT_SLOTS + 2) dial_digit($urandom_range(1, 2), 0);
    idle_ticks_for(3);
    wait_for_results();
    set_register(CFG_TIMEOUT, 16'd1);
    idle_ticks_for(2);
    wait_for_results();
  endtask

  // timeout of 1: the number leaves while the next digit is being dialed
  task automatic test_send_while_dialing();
    set_register(CFG_TIMEOUT, 16'd1);
    dial_digit(2, 0);
    dial_digit(4, 0);
    dial_digit(7, 0);
    idle_ticks_for(3);
    wait_for_results();
  endtask

  // phases of random settings; mostly clean dialing, some noise and torn digits
  task automatic test_random_dialing();
    int first_tick;
    int r;
    int events;
    int count;
    first_tick = tick_count;
    while (tick_count - first_tick < 30 || tick_count < 320) begin
      r = $urandom_range(0, 9);
      set_register(CFG_GUARD, (r < 5) ? 16'd1 : (r < 8) ? 16'($urandom_range(2, 4))
                                                         : 16'($urandom_range(5, 12)));
      set_register(CFG_TIMEOUT, ($urandom_range(0, 19) == 0) ? 16'hFFFF
                                                              : 16'($urandom_range(1, 24)));
      r = $urandom_range(0, 2);
      tick_gap_max = (r == 0) ? 0 : (r == 1) ? 2 : 12;
      pop_gap_max = $urandom_range(0, 1) ? 12 : 0;
      events = $urandom_range(1, 5);
      repeat (events) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          r = $urandom_range(0, 99);
          if (r < 2) count = 33;
          else if (r < 8) count = $urandom_range(0, 1) ? 0 : $urandom_range(11, 12);
          else count = $urandom_range(1, 10);
          dial_digit(count, 10);
        end else if (r < 88) begin
          repeat ($urandom_range(1, 8))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          // torn digit: random pulse activity, release at an arbitrary point
          send_tick(1'b0, 1'($urandom_range(0, 1)));
          repeat ($urandom_range(1, 10)) send_tick(1'b0, 1'($urandom_range(0, 1)));
          send_tick(1'b1, 1'($urandom_range(0, 1)));
        end
      end
      // usually let the timeout run out; sometimes carry the digits over
      if (timeout_ticks <= 40 && $urandom_range(0, 4) != 0)
        repeat (int'(timeout_ticks) + $urandom_range(1, 3))
          send_tick(1'b1, 1'($urandom_range(0, 1)));
      wait_for_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    push = 1'b0;
    dial_line = 1'b1;
    pulse_line = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_GUARD;
    cfg_data = '0;
    guard_ticks = GUARD_RESET;
    timeout_ticks = TIMEOUT_RESET;
    dial_was = 1'b1;
    pulse_was = 1'b1;
    pulse_tally = '0;
    since_pulse = '0;
    idle_ticks = '0;
    digits_stored = 0;
    number_ready = 1'b0;
    tick_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    tick_gap_max = 12;
    pop_gap_max = 12;
    pop_wait = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_line_extremes();
    test_bad_counts();
    test_guard_limits();
    test_full_store();
    test_send_while_dialing();
    test_random_dialing();
    wait_for_results();

    if (pending_digits.size() != 0) begin
      mismatch_count++;
      $display("tb: %0d expected digit beats never arrived", pending_digits.size());
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rdp_pkg.sv
design/rdp_front.sv
design/rdp_cmd_fifo.sv
design/rdp_back.sv
design/rotary_dial_pulse_decoder.sv
tb/sv/rotary_dial_pulse_decoder_tb.sv
